@@ rtl/strongly_connected_components_macros.svh @@
// Assertion helpers for the strongly connected components block
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
// same-cycle implication
`define SCC_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;
   localparam int MAX_NODES_DEF = 64;
   localparam int MAX_EDGES_DEF = 1024;
   localparam int NODE_W        = 6;
   localparam int COUNT_W       = 7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1_ROOT,
      ST_P1_FETCH,
      ST_P1_CHECK,
      ST_P1_POP,
      ST_P2_ROOT,
      ST_P2_ROOTRD,
      ST_P2_FETCH,
      ST_P2_CHECK,
      ST_P2_POP,
      ST_OUT_RD,
      ST_OUT_SHOW
   } state_type;
endpackage

@@ rtl/strongly_connected_components.sv @@
// ----------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju strongly connected components over a streamed directed graph.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries edges, one beat each; req_tlast marks the last beat of a
//   graph and starts the run. Edges naming a node at or above node_count
//   (0 counts as 1), or arriving with the edge store full, are dropped and
//   flagged. csr_we/csr_wdata write node_count; the user does so only while
//   the block is idle, which the block does not enforce. rsp_* then returns
//   one beat per node in ascending order, rsp_tlast on the last node.
// Flow:
//   Non-final edge beats are accepted back to back while idle. After the
//   final beat the first walk scans the edge memory once per visited node,
//   and the reverse walk does the same; both read edges through the single
//   read port of the edge memory. Each output beat is read from the
//   component memory and then shown, holding through any receiver stall.
// Reset clears the control state, edge count and drop flag; node_count
//   returns to 1. While rsp_tready is low the result beat holds and no new
//   input beat is accepted.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
   parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // edge_from[5:0], edge_to[11:6], zero pad
   input  logic        req_tuser,   // edge_present
   input  logic        req_tlast,   // final_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // node_index[5:0], component_id[12:6],
                                    // component_total[19:13], zero pad
   output logic        rsp_tuser,   // input_dropped
   output logic        rsp_tlast    // final_result
);
   localparam int NW  = scc_pkg::NODE_W;
   localparam int CW  = scc_pkg::COUNT_W;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int SW  = NW + ECW;

   scc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  node_count_ff;
   logic [CW-1:0]  n_eff;
   logic [ECW-1:0] edges_ff, edges_in;
   logic           drop_ff, drop_in;

   // edge memory {to, from}
   logic [2*NW-1:0] edge_mem [MAX_EDGES];
   logic [2*NW-1:0] edge_q;
   logic            edge_re;
   logic [EAW-1:0]  edge_ra;

   // walk stack {node, cursor}
   logic [SW-1:0]   stk_mem [MAX_NODES];
   logic [SW-1:0]   stk_q;
   logic            stk_we, stk_re;
   logic [NW-1:0]   stk_wa, stk_ra;
   logic [SW-1:0]   stk_wd;

   // finish order and component memories
   logic [NW-1:0]   fin_mem [MAX_NODES];
   logic [NW-1:0]   fin_q;
   logic            fin_we, fin_re;
   logic [CW-1:0]   comp_mem [MAX_NODES];
   logic [CW-1:0]   comp_q;
   logic            comp_we, comp_re;
   logic [NW-1:0]   comp_wa, comp_ra;

   logic [MAX_NODES-1:0] visited_ff, visited_in, marked_ff, marked_in;
   logic [NW-1:0]   top_node_ff, top_node_in;
   logic [ECW-1:0]  top_cur_ff, top_cur_in;
   logic [CW-1:0]   sp_ff, sp_in;
   logic [CW-1:0]   root_ff, root_in;     // root scan / finish index / out node
   logic [CW-1:0]   fin_cnt_ff, fin_cnt_in;
   logic [CW-1:0]   comp_ff, comp_in;

   logic [NW-1:0]   e_from, e_to, q_from, q_to;
   logic            req_acc, edge_ok;

   assign e_from  = req_tdata[NW-1:0];
   assign e_to    = req_tdata[2*NW-1:NW];
   assign q_from  = edge_q[NW-1:0];
   assign q_to    = edge_q[2*NW-1:NW];
   assign req_acc = req_tvalid && req_tready;
   assign n_eff   = (node_count_ff == '0) ? CW'(1) :
                    (node_count_ff > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count_ff;
   assign edge_ok = req_tuser && ({1'b0, e_from} < n_eff) && ({1'b0, e_to} < n_eff)
                    && (edges_ff < ECW'(MAX_EDGES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scc_pkg::ST_IDLE:      if (req_acc && req_tlast) state_in = scc_pkg::ST_P1_ROOT;
         scc_pkg::ST_P1_ROOT: begin
            if (root_ff == n_eff) state_in = scc_pkg::ST_P2_ROOT;
            else if (!visited_ff[root_ff[NW-1:0]]) state_in = scc_pkg::ST_P1_FETCH;
         end
         scc_pkg::ST_P1_FETCH: begin
            if (top_cur_ff < edges_ff) state_in = scc_pkg::ST_P1_CHECK;
            else if (sp_ff == CW'(1)) state_in = scc_pkg::ST_P1_ROOT;
            else state_in = scc_pkg::ST_P1_POP;
         end
         scc_pkg::ST_P1_CHECK:  state_in = scc_pkg::ST_P1_FETCH;
         scc_pkg::ST_P1_POP:    state_in = scc_pkg::ST_P1_FETCH;
         scc_pkg::ST_P2_ROOT:
            state_in = (root_ff == '0) ? scc_pkg::ST_OUT_RD : scc_pkg::ST_P2_ROOTRD;
         scc_pkg::ST_P2_ROOTRD:
            state_in = marked_ff[fin_q] ? scc_pkg::ST_P2_ROOT : scc_pkg::ST_P2_FETCH;
         scc_pkg::ST_P2_FETCH: begin
            if (top_cur_ff < edges_ff) state_in = scc_pkg::ST_P2_CHECK;
            else if (sp_ff == '0) state_in = scc_pkg::ST_P2_ROOT;
            else state_in = scc_pkg::ST_P2_POP;
         end
         scc_pkg::ST_P2_CHECK:  state_in = scc_pkg::ST_P2_FETCH;
         scc_pkg::ST_P2_POP:    state_in = scc_pkg::ST_P2_FETCH;
         scc_pkg::ST_OUT_RD:    state_in = scc_pkg::ST_OUT_SHOW;
         scc_pkg::ST_OUT_SHOW: begin
            if (rsp_tready)
               state_in = (root_ff + CW'(1) == n_eff) ? scc_pkg::ST_IDLE : scc_pkg::ST_OUT_RD;
         end
         default:               state_in = scc_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      edges_in    = edges_ff;
      drop_in     = drop_ff;
      visited_in  = visited_ff;
      marked_in   = marked_ff;
      top_node_in = top_node_ff;
      top_cur_in  = top_cur_ff;
      sp_in       = sp_ff;
      root_in     = root_ff;
      fin_cnt_in  = fin_cnt_ff;
      comp_in     = comp_ff;
      edge_re     = 1'b0;
      edge_ra     = top_cur_ff[EAW-1:0];
      stk_we      = 1'b0;
      stk_wa      = '0;
      stk_wd      = '0;
      stk_re      = 1'b0;
      stk_ra      = '0;
      fin_we      = 1'b0;
      fin_re      = 1'b0;
      comp_we     = 1'b0;
      comp_wa     = '0;
      comp_re     = 1'b0;
      comp_ra     = root_ff[NW-1:0];
      unique case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (edge_ok) edges_in = edges_ff + ECW'(1);
               else if (req_tuser) drop_in = 1'b1;
               if (req_tlast) begin
                  visited_in = '0;
                  marked_in  = '0;
                  root_in    = '0;
                  fin_cnt_in = '0;
                  comp_in    = '0;
               end
            end
         end
         scc_pkg::ST_P1_ROOT: begin
            if (root_ff == n_eff) begin
               root_in = fin_cnt_ff;
               sp_in   = '0;
            end else if (visited_ff[root_ff[NW-1:0]]) begin
               root_in = root_ff + CW'(1);
            end else begin
               visited_in[root_ff[NW-1:0]] = 1'b1;
               top_node_in = root_ff[NW-1:0];
               top_cur_in  = '0;
               sp_in       = CW'(1);
            end
         end
         scc_pkg::ST_P1_FETCH: begin
            if (top_cur_ff < edges_ff) begin
               edge_re = 1'b1;
            end else begin
               fin_we     = 1'b1;
               fin_cnt_in = fin_cnt_ff + CW'(1);
               sp_in      = sp_ff - CW'(1);
               if (sp_ff == CW'(1)) root_in = root_ff + CW'(1);
               else begin
                  stk_re = 1'b1;
                  stk_ra = NW'(sp_ff - CW'(2));
               end
            end
         end
         scc_pkg::ST_P1_CHECK: begin
            top_cur_in = top_cur_ff + ECW'(1);
            if (q_from == top_node_ff && !visited_ff[q_to]) begin
               visited_in[q_to] = 1'b1;
               stk_we      = 1'b1;
               stk_wa      = NW'(sp_ff - CW'(1));
               stk_wd      = {top_node_ff, top_cur_ff + ECW'(1)};
               top_node_in = q_to;
               top_cur_in  = '0;
               sp_in       = sp_ff + CW'(1);
            end
         end
         scc_pkg::ST_P1_POP: begin
            top_node_in = stk_q[SW-1:ECW];
            top_cur_in  = stk_q[ECW-1:0];
         end
         scc_pkg::ST_P2_ROOT: begin
            if (root_ff != '0) fin_re = 1'b1;
            else root_in = '0;
         end
         scc_pkg::ST_P2_ROOTRD: begin
            root_in = root_ff - CW'(1);
            if (!marked_ff[fin_q]) begin
               marked_in[fin_q] = 1'b1;
               comp_in     = comp_ff + CW'(1);
               comp_we     = 1'b1;
               comp_wa     = fin_q;
               top_node_in = fin_q;
               top_cur_in  = '0;
               sp_in       = '0;
            end
         end
         scc_pkg::ST_P2_FETCH: begin
            if (top_cur_ff < edges_ff) edge_re = 1'b1;
            else if (sp_ff != '0) begin
               stk_re = 1'b1;
               stk_ra = NW'(sp_ff - CW'(1));
               sp_in  = sp_ff - CW'(1);
            end
         end
         scc_pkg::ST_P2_CHECK: begin
            top_cur_in = top_cur_ff + ECW'(1);
            if (q_to == top_node_ff && !marked_ff[q_from]) begin
               marked_in[q_from] = 1'b1;
               comp_we = 1'b1;
               comp_wa = q_from;
               stk_we  = 1'b1;
               stk_wa  = sp_ff[NW-1:0];
               stk_wd  = {q_from, {ECW{1'b0}}};
               sp_in   = sp_ff + CW'(1);
            end
         end
         scc_pkg::ST_P2_POP: begin
            top_node_in = stk_q[SW-1:ECW];
            top_cur_in  = '0;
         end
         scc_pkg::ST_OUT_RD:   comp_re = 1'b1;
         scc_pkg::ST_OUT_SHOW: begin
            if (rsp_tready) begin
               root_in = root_ff + CW'(1);
               if (root_ff + CW'(1) == n_eff) begin
                  edges_in = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scc_pkg::ST_IDLE;
         node_count_ff <= CW'(1);
         edges_ff      <= '0;
         drop_ff       <= 1'b0;
         sp_ff         <= '0;
         root_ff       <= '0;
         fin_cnt_ff    <= '0;
         comp_ff       <= '0;
         visited_ff    <= '0;
         marked_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         if (csr_we) node_count_ff <= csr_wdata;
         edges_ff   <= edges_in;
         drop_ff    <= drop_in;
         sp_ff      <= sp_in;
         root_ff    <= root_in;
         fin_cnt_ff <= fin_cnt_in;
         comp_ff    <= comp_in;
         visited_ff <= visited_in;
         marked_ff  <= marked_in;
      end
   end

   always_ff @(posedge clock) begin
      top_node_ff <= top_node_in;
      top_cur_ff  <= top_cur_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (req_acc && edge_ok) edge_mem[edges_ff[EAW-1:0]] <= {e_to, e_from};
      if (edge_re) edge_q <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (stk_re) stk_q <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (fin_we) fin_mem[fin_cnt_ff[NW-1:0]] <= top_node_ff;
      if (fin_re) fin_q <= fin_mem[NW'(root_ff - CW'(1))];
   end

   always_ff @(posedge clock) begin
      if (comp_we) comp_mem[comp_wa] <= (state_ff == scc_pkg::ST_P2_ROOTRD) ?
                                        comp_ff + CW'(1) : comp_ff;
      if (comp_re) comp_q <= comp_mem[comp_ra];
   end

   // ports
   assign req_tready = (state_ff == scc_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == scc_pkg::ST_OUT_SHOW);
   assign rsp_tdata  = {4'b0, comp_ff, comp_q, root_ff[NW-1:0]};
   assign rsp_tuser  = drop_ff;
   assign rsp_tlast  = (root_ff + CW'(1) == n_eff);
endmodule

@@ rtl/scc_checker.sv @@
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks on the strongly connected components block.
// ----------------------------------------------------------------------------
`include "strongly_connected_components_macros.svh"
module scc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // a stalled result beat holds
   `SCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // no input beat while results are pending
   `SCC_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // a final beat starts the run
   `SCC_ASSERT_NEXT(a_run_starts, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // every reported node belongs to some component
   `SCC_ASSERT_NOW(a_comp_nonzero, clock, reset, rsp_tvalid, rsp_tdata[12:6] != 7'd0)
endmodule

bind strongly_connected_components scc_checker u_scc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ tb/tb_strongly_connected_components.sv @@
// ----------------------------------------------------------------------------
// tb_strongly_connected_components
// Streams directed graphs into the component finder and checks every node's
// component number, total, drop flag and last-node marker against an
// in-bench Kosaraju predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_strongly_connected_components;

   localparam int NMAX = 64;
   localparam int EMAX = 1024;

   typedef struct packed {
      logic [5:0] node;
      logic [6:0] comp;
      logic [6:0] total;
      logic       dropped;
      logic       last;
   } node_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   strongly_connected_components i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [6:0]      node_count_reg;
   logic [5:0]      edge_src[EMAX];
   logic [5:0]      edge_dst[EMAX];
   int              edges_held;
   bit              drop_seen;
   node_result_type component_queue[$];
   int              error_count;
   int              graphs_run;
   int              results_seen;
   bit              quiet_rx;

   function automatic int live_nodes();
      if (node_count_reg == 0) return 1;
      if (node_count_reg > NMAX) return NMAX;
      return int'(node_count_reg);
   endfunction

   // Kosaraju over the held edges; queues one result per node
   task automatic predict_components();
      int n, sp, done, comp, v, cur, u, w;
      int fwd_off[NMAX+1], rev_off[NMAX+1], fill[NMAX];
      int fwd_ord[EMAX], rev_ord[EMAX];
      int colour[NMAX], finish_seq[NMAX], stk_node[NMAX], stk_cur[NMAX];
      int comp_of[NMAX];
      node_result_type res_item;
      n = live_nodes();
      done = 0;
      comp = 0;
      for (int i = 0; i <= NMAX; i++) begin
         fwd_off[i] = 0;
         rev_off[i] = 0;
      end
      for (int e = 0; e < edges_held; e++) begin
         fwd_off[edge_src[e] + 1]++;
         rev_off[edge_dst[e] + 1]++;
      end
      for (int i = 0; i < n; i++) begin
         fwd_off[i+1] += fwd_off[i];
         rev_off[i+1] += rev_off[i];
      end
      for (int i = 0; i < n; i++) fill[i] = fwd_off[i];
      for (int e = 0; e < edges_held; e++) fwd_ord[fill[edge_src[e]]++] = e;
      for (int i = 0; i < n; i++) fill[i] = rev_off[i];
      for (int e = 0; e < edges_held; e++) rev_ord[fill[edge_dst[e]]++] = e;
      for (int i = 0; i < NMAX; i++) begin
         colour[i] = 0;
         comp_of[i] = 0;
      end
      // forward walk, recording finish order
      for (int s = 0; s < n; s++) begin
         if (colour[s] != 0) continue;
         colour[s] = 1;
         stk_node[0] = s;
         stk_cur[0] = fwd_off[s];
         sp = 1;
         while (sp > 0) begin
            v = stk_node[sp-1];
            cur = stk_cur[sp-1];
            if (cur < fwd_off[v+1]) begin
               u = edge_dst[fwd_ord[cur]];
               stk_cur[sp-1] = cur + 1;
               if (colour[u] == 0 && sp < NMAX) begin
                  colour[u] = 1;
                  stk_node[sp] = u;
                  stk_cur[sp] = fwd_off[u];
                  sp++;
               end
            end else begin
               colour[v] = 2;
               if (done < NMAX) finish_seq[done++] = v;
               sp--;
            end
         end
      end
      // reverse walk in reverse finish order
      for (int i = done; i > 0; i--) begin
         v = finish_seq[i-1];
         if (comp_of[v] != 0) continue;
         comp++;
         comp_of[v] = comp;
         stk_node[0] = v;
         sp = 1;
         while (sp > 0) begin
            sp--;
            w = stk_node[sp];
            for (int k = rev_off[w]; k < rev_off[w+1]; k++) begin
               u = edge_src[rev_ord[k]];
               if (comp_of[u] == 0 && sp < NMAX) begin
                  comp_of[u] = comp;
                  stk_node[sp++] = u;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         res_item = '{node: i[5:0], comp: comp_of[i][6:0],
            total: comp[6:0], dropped: drop_seen, last: (i == n - 1)};
         component_queue = {component_queue, res_item};
      end
      edges_held = 0;
      drop_seen = 0;
      graphs_run++;
   endtask

   // send one beat and update the predictor on acceptance; valid stays up
   // after the accepting edge so a following beat can go out with no gap
   task automatic send_edge(input int src, input int dst, input bit present,
                            input bit fin);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, dst[5:0], src[5:0]};
      req_tuser  <= present;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (present) begin
         if (src >= live_nodes() || dst >= live_nodes() || edges_held >= EMAX)
            drop_seen = 1;
         else begin
            edge_src[edges_held] = src[5:0];
            edge_dst[edges_held] = dst[5:0];
            edges_held++;
         end
      end
      if (fin) predict_components();
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (component_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(input int value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value[6:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      node_count_reg = value[6:0];
   endtask

   // receiver ready with random stalls
   always @(posedge clock) begin
      if (reset || quiet_rx) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 7) < 5);
   end

   // result checker
   always @(posedge clock) begin
      node_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (component_queue.size() == 0) begin
            $error("unexpected result beat node=%0d", rsp_tdata[5:0]);
            error_count++;
         end else begin
            exp_r = component_queue.pop_front();
            if (rsp_tdata[5:0] !== exp_r.node) begin
               $error("node_index exp %0d got %0d", exp_r.node, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[12:6] !== exp_r.comp) begin
               $error("component_id exp %0d got %0d", exp_r.comp, rsp_tdata[12:6]);
               error_count++;
            end
            if (rsp_tdata[19:13] !== exp_r.total) begin
               $error("component_total exp %0d got %0d", exp_r.total,
                      rsp_tdata[19:13]);
               error_count++;
            end
            if (rsp_tuser !== exp_r.dropped) begin
               $error("input_dropped exp %0d got %0d", exp_r.dropped, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("final_result exp %0d got %0d", exp_r.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // ---- tests ----
   task automatic test_defaults();
      // reset node count of 1: self loop, bare marker, bad index
      send_edge(0, 0, 1, 1);
      send_edge(0, 0, 0, 1);
      send_edge(63, 0, 1, 0);
      send_edge(0, 63, 1, 1);
   endtask

   task automatic test_small_cycles();
      write_node_count(4);
      // cycle 0-1-2, node 3 alone, duplicate edge, edge on final beat
      send_edge(0, 1, 1, 0);
      send_edge(1, 2, 1, 0);
      send_edge(1, 2, 1, 0);
      send_edge(3, 3, 1, 0);
      send_edge(2, 0, 1, 1);
      send_edge(4, 1, 1, 0);
      send_edge(2, 3, 1, 1);
   endtask

   task automatic test_extremes();
      write_node_count(0);
      send_edge(0, 0, 1, 1);
      write_node_count(127);
      send_edge(63, 0, 1, 0);
      send_edge(0, 63, 1, 0);
      send_edge(42, 21, 1, 1);
      write_node_count(64);
      send_edge(21, 42, 0, 1);
   endtask

   task automatic test_dense_graph();
      // many edges over few nodes, a few naming nodes out of range
      write_node_count(8);
      for (int i = 0; i < 40; i++) begin
         if (i % 13 == 5) send_edge(8 + (i % 5), i % 8, 1, 0);
         else send_edge($urandom_range(0, 7), $urandom_range(0, 7), 1, 0);
      end
      send_edge(0, 0, 0, 1);
   endtask

   task automatic test_random_graphs();
      int n, len, cnt;
      cnt = 0;
      while (cnt < 220) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64)
                                           : $urandom_range(1, 10);
         write_node_count(n);
         len = $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_edge($urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1), 0);
            else
               send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), 1, 0);
            cnt++;
         end
         send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   $urandom_range(0, 1), 1);
         cnt++;
         // let the results run out with no receiver stalls now and then
         if ($urandom_range(0, 9) == 0) begin
            quiet_rx = 1;
            drain_results();
            quiet_rx = 0;
         end
      end
   endtask

   initial begin
      node_count_reg = 1;
      edges_held = 0;
      drop_seen = 0;
      error_count = 0;
      graphs_run = 0;
      results_seen = 0;
      quiet_rx = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_small_cycles();
      test_extremes();
      test_dense_graph();
      test_random_graphs();
      drain_results();
      repeat (50) @(posedge clock);
      $display("Ran %0d graphs (node counts 0..127 incl. overflow, bad indices,",
               graphs_run);
      $display("  dense edge sets), checked %0d node beats.", results_seen);
      if (error_count == 0 && component_queue.size() == 0)
         $display("tb_strongly_connected_components: clean");
      else
         $display("tb_strongly_connected_components: errors");
      $finish;
   end

   // watchdog
   initial begin
      #400ms;
      $display("tb_strongly_connected_components: errors");
      $finish;
   end
endmodule
